@@ design/bffa_pkg.sv @@
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int POOL_UNITS  = 1024;
    localparam int UNIT_BYTES  = 16;
    localparam int POOL_BYTES  = 16384;

    localparam int WORD_BITS   = 32;
    localparam int WORD_SHIFT  = $clog2(WORD_BITS);
    localparam int MAP_WORDS   = POOL_UNITS / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int UNIT_W      = $clog2(POOL_UNITS);
    localparam int CNT_W       = UNIT_W + 1;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int FIRST_START = 32;
    localparam int SCAN_STEP   = 8;
    localparam int STEP_SHIFT  = $clog2(SCAN_STEP);
    localparam int LAST_POS    = POOL_UNITS - SCAN_STEP;
    localparam int ADDR_W      = 34;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_BAD       = 2'd1,
        ST_NOSPACE   = 2'd2,
        ST_ALIGN_OVF = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_ADDR,
        S_ALIGN,
        S_CHECK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] word;
        logic [WORD_SHIFT-1:0] lo;
        logic [WORD_SHIFT-1:0] hi;
    } map_wr_t;

    typedef struct packed {
        logic              found;
        logic [UNIT_W-1:0] start;
        logic [CNT_W-1:0]  run_len;
        logic [CNT_W-1:0]  run_start;
    } scan_res_t;

endpackage

@@ design/bffa_run_scan.sv @@
`timescale 1ns / 1ps

module bffa_run_scan (
    input  logic [bffa_pkg::SCAN_STEP-1:0] chunk,
    input  logic [bffa_pkg::UNIT_W-1:0]    pos,
    input  logic [bffa_pkg::CNT_W-1:0]     run_len,
    input  logic [bffa_pkg::CNT_W-1:0]     run_start,
    input  logic [bffa_pkg::CNT_W-1:0]     needed,
    output bffa_pkg::scan_res_t            res
);
    import bffa_pkg::*;

    always_comb begin
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  st;
        logic              found;
        logic [UNIT_W-1:0] fs;
        len   = run_len;
        st    = run_start;
        found = 1'b0;
        fs    = '0;
        for (int i = 0; i < SCAN_STEP; i++) begin
            if (!found) begin
                if (chunk[i]) begin
                    len = '0;
                    st  = CNT_W'({1'b0, pos}) + CNT_W'(i + 1);
                end else begin
                    len = len + CNT_W'(1);
                    if (len == needed) begin
                        found = 1'b1;
                        fs    = st[UNIT_W-1:0];
                    end
                end
            end
        end
        res.found     = found;
        res.start     = fs;
        res.run_len   = len;
        res.run_start = st;
    end

endmodule

@@ design/bffa_map.sv @@
`timescale 1ns / 1ps

module bffa_map (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bffa_pkg::WORD_IDX_W-1:0] rd_word,
    output logic [bffa_pkg::WORD_BITS-1:0]  rd_data,
    input  bffa_pkg::map_wr_t               wr
);
    import bffa_pkg::*;

    logic [WORD_BITS-1:0] map_reg [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WORD_BITS-1:0] mask;

    // bits lo..hi inclusive
    assign mask = ({WORD_BITS{1'b1}} << wr.lo)
                & ({WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - wr.hi));

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= map_reg[rd_word];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                map_reg[w] <= '0;
            end
        end else if (wr.en) begin
            map_reg[wr.word] <= map_reg[wr.word] | mask;
        end
    end

endmodule

@@ design/bitmap_first_fit_allocator_unit.sv @@
`timescale 1ns / 1ps

// First-fit unit allocator over a used-unit bitmap.
// Input channel s_*: one request per transaction (byte size, alignment exponent).
// Output channel m_*: one status/address result per request.
// cfg_we/cfg_wdata write the pool base address; write only while idle.
// A request is taken only in idle; s_ready stays low until its result has been
// loaded into the output register, so one request is in flight at a time.
// Bad requests go from idle straight to the result state, without a scan.
// Otherwise the map is scanned 8 units per cycle from unit 32 upward by the
// 8-unit run scanner, then the found run is marked one map word per cycle,
// then S_ADDR, S_ALIGN and S_CHECK form the address, align it and check its
// range, then S_RESULT loads the output register once that register is free.
// If the receiver stalls, the result waits in the output register; the next
// request may be accepted meanwhile, and its result waits until it is taken.
// Reset (synchronous, active low) clears the map to all free, the pool base
// to zero, and empties the output register.
module bitmap_first_fit_allocator_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [19:0]          s_request_size,
    input  logic [4:0]           s_align_log2,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [31:0]          m_address
);
    import bffa_pkg::*;

    state_t                state_reg, state_next;
    logic [31:0]           pool_base_reg;
    logic [19:0]           size_reg, size_next;
    logic [4:0]            alog_reg, alog_next;
    logic [CNT_W-1:0]      needed_reg, needed_next;
    logic [UNIT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]      run_len_reg, run_len_next;
    logic [CNT_W-1:0]      run_start_reg, run_start_next;
    logic [UNIT_W-1:0]     start_reg, start_next;
    logic [UNIT_W-1:0]     last_reg, last_next;
    logic [WORD_IDX_W-1:0] mark_word_reg, mark_word_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     pool_lim_reg, pool_lim_next;
    logic [ADDR_W-1:0]     aligned_reg, aligned_next;
    status_t               res_status_reg, res_status_next;
    logic [31:0]           res_addr_reg, res_addr_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [31:0]           m_address_reg, m_address_next;

    logic [WORD_BITS-1:0]  rd_data;
    logic [SCAN_STEP-1:0]  chunk;
    scan_res_t             scan;
    map_wr_t               map_wr;
    logic                  bad_req;
    logic [ADDR_W-1:0]     amask;
    logic [20:0]           size_round;

    assign chunk = rd_data[{pos_reg[WORD_SHIFT-1:STEP_SHIFT], STEP_SHIFT'(0)} +: SCAN_STEP];

    // map word is read through a register, addressed from the next scan position
    bffa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_word (pos_next[UNIT_W-1:WORD_SHIFT]),
        .rd_data (rd_data),
        .wr      (map_wr)
    );

    bffa_run_scan u_scan (
        .chunk     (chunk),
        .pos       (pos_reg),
        .run_len   (run_len_reg),
        .run_start (run_start_reg),
        .needed    (needed_reg),
        .res       (scan)
    );

    assign bad_req = (pool_base_reg == 32'd0) || (s_request_size == 20'd0)
                   || (32'(s_request_size) > 32'(POOL_BYTES));
    assign size_round = {1'b0, s_request_size} + 21'(UNIT_BYTES - 1);
    assign amask = (ADDR_W'(1) << alog_reg) - ADDR_W'(1);

    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        alog_next       = alog_reg;
        needed_next     = needed_reg;
        pos_next        = pos_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        start_next      = start_reg;
        last_next       = last_reg;
        mark_word_next  = mark_word_reg;
        addr_next       = addr_reg;
        pool_lim_next   = pool_lim_reg;
        aligned_next    = aligned_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_address_next  = m_address_reg;
        map_wr.en       = 1'b0;
        map_wr.word     = mark_word_reg;
        map_wr.lo       = '0;
        map_wr.hi       = WORD_SHIFT'(WORD_BITS - 1);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    size_next     = s_request_size;
                    alog_next     = s_align_log2;
                    needed_next   = CNT_W'(size_round >> UNIT_SHIFT);
                    pos_next      = UNIT_W'(FIRST_START);
                    run_len_next  = '0;
                    run_start_next = CNT_W'(FIRST_START);
                    pool_lim_next = ADDR_W'(pool_base_reg) + ADDR_W'(POOL_BYTES);
                    if (bad_req) begin
                        res_status_next = ST_BAD;
                        res_addr_next   = '0;
                        state_next      = S_RESULT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan.found) begin
                    start_next     = scan.start;
                    last_next      = scan.start + UNIT_W'(needed_reg - CNT_W'(1));
                    mark_word_next = scan.start[UNIT_W-1:WORD_SHIFT];
                    state_next     = S_MARK;
                end else if (pos_reg == UNIT_W'(LAST_POS)) begin
                    res_status_next = ST_NOSPACE;
                    res_addr_next   = '0;
                    state_next      = S_RESULT;
                end else begin
                    pos_next       = pos_reg + UNIT_W'(SCAN_STEP);
                    run_len_next   = scan.run_len;
                    run_start_next = scan.run_start;
                end
            end
            S_MARK: begin
                map_wr.en = 1'b1;
                if (mark_word_reg == start_reg[UNIT_W-1:WORD_SHIFT]) begin
                    map_wr.lo = start_reg[WORD_SHIFT-1:0];
                end
                if (mark_word_reg == last_reg[UNIT_W-1:WORD_SHIFT]) begin
                    map_wr.hi  = last_reg[WORD_SHIFT-1:0];
                    state_next = S_ADDR;
                end else begin
                    mark_word_next = mark_word_reg + WORD_IDX_W'(1);
                end
            end
            S_ADDR: begin
                addr_next  = ADDR_W'(pool_base_reg) + (ADDR_W'(start_reg) << UNIT_SHIFT);
                state_next = S_ALIGN;
            end
            S_ALIGN: begin
                aligned_next = (addr_reg + amask) & ~amask;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                if ((aligned_reg + ADDR_W'(size_reg) > pool_lim_reg)
                    || (aligned_reg[ADDR_W-1:32] != '0)) begin
                    res_status_next = ST_ALIGN_OVF;
                    res_addr_next   = '0;
                end else begin
                    res_status_next = ST_GRANTED;
                    res_addr_next   = aligned_reg[31:0];
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_address_next = res_addr_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            pool_base_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                pool_base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        alog_reg       <= alog_next;
        needed_reg     <= needed_next;
        pos_reg        <= pos_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        start_reg      <= start_next;
        last_reg       <= last_next;
        mark_word_reg  <= mark_word_next;
        addr_reg       <= addr_next;
        pool_lim_reg   <= pool_lim_next;
        aligned_reg    <= aligned_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_address_reg  <= m_address_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;

`ifndef SYNTHESIS
    a_fail_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_GRANTED)) |-> (m_address == 32'd0))
        else $error("failed request carries nonzero address");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_mark_after_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && scan.found) |=> (state_reg == S_MARK && map_wr.en))
        else $error("found run not marked");
`endif

endmodule
